// ===== rtl/tmr_pkg.sv =====
// shared types and constants for the touch to relative mouse block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tmr_pkg;

   localparam int CoordBits     = 10;
   localparam int DiffBits      = 8;
   localparam int GainBits      = 3;
   localparam int ThreshBits    = 8;
   localparam int ProdBits      = DiffBits + GainBits;
   localparam int CsrIndexBits  = 2;
   localparam int CsrDataBits   = 8;
   localparam int QueueDepth    = 4;
   localparam int QueuePtrBits  = $clog2(QueueDepth);
   localparam int QueueCntBits  = $clog2(QueueDepth + 1);

   localparam logic [CsrIndexBits-1:0] CsrClickThreshold = CsrIndexBits'(0);
   localparam logic [CsrIndexBits-1:0] CsrMotionGain     = CsrIndexBits'(1);

   localparam logic [ThreshBits-1:0] ThreshReset = ThreshBits'(3);
   localparam logic [GainBits-1:0]   GainReset   = GainBits'(3);

   typedef enum logic {
      CmdMotion,
      CmdTap
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [DiffBits-1:0] dx;
      logic [DiffBits-1:0] dy;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== rtl/tmr_front.sv =====
// front part: accepts touch samples, tracks contact state, classifies into commands
// depends on tmr_pkg
`timescale 1ns / 1ps
`default_nettype none

module tmr_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  wire logic                                req_touched,
   input  wire logic [tmr_pkg::CoordBits-1:0]       req_touch_x,
   input  wire logic [tmr_pkg::CoordBits-1:0]       req_touch_y,
   input  wire logic [tmr_pkg::ThreshBits-1:0]      click_threshold,
   output      logic                                push,
   output      tmr_pkg::cmd_type                    push_cmd
);

   logic                            tracking_ff, tracking_in;
   logic                            tap_pending_ff, tap_pending_in;
   logic [tmr_pkg::CoordBits-1:0]   prev_x_ff, prev_x_in;
   logic [tmr_pkg::CoordBits-1:0]   prev_y_ff, prev_y_in;
   logic [tmr_pkg::CoordBits-1:0]   start_x_ff, start_x_in;
   logic [tmr_pkg::CoordBits-1:0]   start_y_ff, start_y_in;
   logic [tmr_pkg::CoordBits-1:0]   dist_x, dist_y, thresh_ext;
   logic [tmr_pkg::CoordBits-1:0]   diff_x, diff_y;
   logic                            accept, moved_away;

   assign accept     = req_valid && !req_stall;
   assign thresh_ext = tmr_pkg::CoordBits'(click_threshold);
   assign dist_x     = (req_touch_x >= start_x_ff) ? (req_touch_x - start_x_ff)
                                                   : (start_x_ff - req_touch_x);
   assign dist_y     = (req_touch_y >= start_y_ff) ? (req_touch_y - start_y_ff)
                                                   : (start_y_ff - req_touch_y);
   assign moved_away = (dist_x > thresh_ext) || (dist_y > thresh_ext);
   assign diff_x     = req_touch_x - prev_x_ff;
   assign diff_y     = req_touch_y - prev_y_ff;

   always_comb begin
      tracking_in    = tracking_ff;
      tap_pending_in = tap_pending_ff;
      prev_x_in      = prev_x_ff;
      prev_y_in      = prev_y_ff;
      start_x_in     = start_x_ff;
      start_y_in     = start_y_ff;
      push           = 1'b0;
      push_cmd.kind  = tmr_pkg::CmdMotion;
      push_cmd.dx    = diff_x[tmr_pkg::DiffBits-1:0];
      push_cmd.dy    = diff_y[tmr_pkg::DiffBits-1:0];
      if (accept) begin
         if (req_touched) begin
            prev_x_in = req_touch_x;
            prev_y_in = req_touch_y;
            if (!tracking_ff) begin
               tracking_in    = 1'b1;
               tap_pending_in = 1'b1;
               start_x_in     = req_touch_x;
               start_y_in     = req_touch_y;
            end else begin
               push = 1'b1;
               if (moved_away) begin
                  tap_pending_in = 1'b0;
               end
            end
         end else begin
            tracking_in = 1'b0;
            if (tap_pending_ff) begin
               tap_pending_in = 1'b0;
               push           = 1'b1;
               push_cmd.kind  = tmr_pkg::CmdTap;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracking_ff    <= 1'b0;
         tap_pending_ff <= 1'b0;
      end else begin
         tracking_ff    <= tracking_in;
         tap_pending_ff <= tap_pending_in;
      end
      prev_x_ff  <= prev_x_in;
      prev_y_ff  <= prev_y_in;
      start_x_ff <= start_x_in;
      start_y_ff <= start_y_in;
   end

`ifndef SYNTHESIS
   a_tap_needs_tracking: assert property (@(posedge clock) disable iff (reset)
      tap_pending_ff |-> tracking_ff)
      else $error("tap armed while not tracking");
`endif

endmodule

`default_nettype wire

// ===== rtl/tmr_queue.sv =====
// short command queue between the front and back parts
// depends on tmr_pkg
`timescale 1ns / 1ps
`default_nettype none

module tmr_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire tmr_pkg::cmd_type           push_cmd,
   input  wire logic                       pop,
   output      tmr_pkg::cmd_type           head_cmd,
   output      tmr_pkg::queue_status_type  status
);

   tmr_pkg::cmd_type                   entry_ff [tmr_pkg::QueueDepth];
   logic [tmr_pkg::QueuePtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [tmr_pkg::QueuePtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [tmr_pkg::QueueCntBits-1:0]   count_ff, count_in;

   assign status.full      = (count_ff == tmr_pkg::QueueCntBits'(tmr_pkg::QueueDepth));
   assign status.not_empty = (count_ff != '0);
   assign head_cmd         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !status.not_empty |-> !pop)
      else $error("pop from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tmr_pkg::QueueCntBits'(tmr_pkg::QueueDepth))
      else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/tmr_back.sv =====
// back part: scales motion, expands taps into press and release reports
// depends on tmr_pkg
`timescale 1ns / 1ps
`default_nettype none

module tmr_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire tmr_pkg::queue_status_type        status,
   input  wire tmr_pkg::cmd_type                 head_cmd,
   input  wire logic [tmr_pkg::GainBits-1:0]     motion_gain,
   output      logic                             pop,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output      logic                             rsp_left_button,
   output      logic signed [7:0]                rsp_move_x,
   output      logic signed [7:0]                rsp_move_y,
   output      logic                             rsp_last_of_run
);

   logic                              valid_ff, valid_in;
   logic                              release_due_ff, release_due_in;
   logic                              button_ff, button_in;
   logic [tmr_pkg::DiffBits-1:0]      move_x_ff, move_x_in;
   logic [tmr_pkg::DiffBits-1:0]      move_y_ff, move_y_in;
   logic                              last_ff, last_in;
   logic [tmr_pkg::ProdBits-1:0]      prod_x, prod_y;
   logic                              load;

   assign load   = !valid_ff || !rsp_stall;
   assign pop    = load && !release_due_ff && status.not_empty;
   assign prod_x = tmr_pkg::ProdBits'(head_cmd.dx) * tmr_pkg::ProdBits'(motion_gain);
   assign prod_y = tmr_pkg::ProdBits'(head_cmd.dy) * tmr_pkg::ProdBits'(motion_gain);

   always_comb begin
      valid_in       = valid_ff;
      release_due_in = release_due_ff;
      button_in      = button_ff;
      move_x_in      = move_x_ff;
      move_y_in      = move_y_ff;
      last_in        = last_ff;
      if (load) begin
         if (release_due_ff) begin
            valid_in       = 1'b1;
            release_due_in = 1'b0;
            button_in      = 1'b0;
            move_x_in      = '0;
            move_y_in      = '0;
            last_in        = 1'b1;
         end else if (status.not_empty) begin
            valid_in = 1'b1;
            unique case (head_cmd.kind)
               tmr_pkg::CmdTap: begin
                  release_due_in = 1'b1;
                  button_in      = 1'b1;
                  move_x_in      = '0;
                  move_y_in      = '0;
                  last_in        = 1'b0;
               end
               default: begin
                  button_in = 1'b0;
                  move_x_in = prod_x[tmr_pkg::DiffBits-1:0];
                  move_y_in = prod_y[tmr_pkg::DiffBits-1:0];
                  last_in   = 1'b1;
               end
            endcase
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         release_due_ff <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         release_due_ff <= release_due_in;
      end
      button_ff <= button_in;
      move_x_ff <= move_x_in;
      move_y_ff <= move_y_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_left_button = button_ff;
   assign rsp_move_x      = move_x_ff;
   assign rsp_move_y      = move_y_ff;
   assign rsp_last_of_run = last_ff;

`ifndef SYNTHESIS
   a_release_follows_press: assert property (@(posedge clock) disable iff (reset)
      release_due_ff |-> valid_ff && button_ff && !last_ff)
      else $error("release pending without press on output");
   a_press_not_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && button_ff |-> !last_ff && release_due_ff)
      else $error("press request marked last");
`endif

endmodule

`default_nettype wire

// ===== rtl/touch_to_relative_mouse.sv =====
// top level of the touch to relative mouse block: csr registers and part wiring
// depends on tmr_pkg, tmr_front, tmr_queue, tmr_back
`timescale 1ns / 1ps
`default_nettype none

// Turns touch-panel samples into relative mouse requests. A sample is taken in
// every cycle in which req_valid is high and req_stall is low; the first touched
// sample of a contact only latches the position, each later touched sample gives
// one motion request, and a release with a tap still armed gives a press request
// and then a release request. The front part updates the contact state and hands
// commands to a four-entry queue; the back part scales motion with an 8x3
// multiply per axis into the output register, so one sample and one request
// move per cycle while req_stall and rsp_stall are low. Each command passes the
// queue entry register and the output register. click_threshold (index 0) and
// motion_gain (index 1) are written through the csr port, which is always ready.

module touch_to_relative_mouse (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire logic [tmr_pkg::CsrIndexBits-1:0]      csr_index,
   input  wire logic [tmr_pkg::CsrDataBits-1:0]       csr_wdata,
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire logic                                  req_touched,
   input  wire logic [tmr_pkg::CoordBits-1:0]         req_touch_x,
   input  wire logic [tmr_pkg::CoordBits-1:0]         req_touch_y,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      logic                                  rsp_left_button,
   output      logic signed [7:0]                     rsp_move_x,
   output      logic signed [7:0]                     rsp_move_y,
   output      logic                                  rsp_last_of_run
);

   logic [tmr_pkg::ThreshBits-1:0]   threshold_ff;
   logic [tmr_pkg::GainBits-1:0]     gain_ff;
   logic                             push, pop;
   tmr_pkg::cmd_type                 push_cmd, head_cmd;
   tmr_pkg::queue_status_type        status;

   assign csr_ready = 1'b1;
   assign req_stall = status.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= tmr_pkg::ThreshReset;
         gain_ff      <= tmr_pkg::GainReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            tmr_pkg::CsrClickThreshold: threshold_ff <= csr_wdata[tmr_pkg::ThreshBits-1:0];
            tmr_pkg::CsrMotionGain:     gain_ff      <= csr_wdata[tmr_pkg::GainBits-1:0];
            default: ;
         endcase
      end
   end

   tmr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_touched     (req_touched),
      .req_touch_x     (req_touch_x),
      .req_touch_y     (req_touch_y),
      .click_threshold (threshold_ff),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   tmr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (status)
   );

   tmr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .status          (status),
      .head_cmd        (head_cmd),
      .motion_gain     (gain_ff),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_button (rsp_left_button),
      .rsp_move_x      (rsp_move_x),
      .rsp_move_y      (rsp_move_y),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire
